// ===== design/ps2_mouse_cursor_tracker_defines.svh =====
// Assertion helpers for the cursor tracker.
`ifndef PS2_MOUSE_CURSOR_TRACKER_DEFINES_SVH
`define PS2_MOUSE_CURSOR_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge out of reset.
`define PS2MCT_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("ps2mct: check failed");

// Antecedent in one cycle implies consequent in the next.
`define PS2MCT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ps2mct: check failed");

`else

`define PS2MCT_ASSERT(lbl, cond)
`define PS2MCT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/ps2mct_pkg.sv =====
package ps2mct_pkg;

    localparam int COORD_BITS = 12;
    localparam int SIZE_W     = COORD_BITS + 1;
    localparam int REG_W      = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

    localparam logic [REG_W-1:0] WIDTH_RESET  = 13'd1024;
    localparam logic [REG_W-1:0] HEIGHT_RESET = 13'd768;

    // flags byte bit positions
    localparam int LEFT_BIT   = 0;
    localparam int RIGHT_BIT  = 1;
    localparam int MIDDLE_BIT = 2;
    localparam int SYNC_BIT   = 3;
    localparam int X_SIGN_BIT = 4;
    localparam int Y_SIGN_BIT = 5;
    localparam int X_OVF_BIT  = 6;
    localparam int Y_OVF_BIT  = 7;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] flags;
        logic [7:0] dx;
        logic [7:0] dy;
    } t_packet;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [REG_W-1:0]     data;
    } t_cfg_wr;

endpackage

// ===== design/ps2mct_framer.sv =====
module ps2mct_framer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    output logic                o_q_push,
    output ps2mct_pkg::t_packet o_q_data
);
    import ps2mct_pkg::*;

    localparam logic [1:0] PH_FLAGS = 2'd0;
    localparam logic [1:0] PH_DX    = 2'd1;
    localparam logic [1:0] PH_DY    = 2'd2;

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_flags, n_flags;
    logic [7:0] r_dx, n_dx;

    always_comb begin
        n_phase  = r_phase;
        n_flags  = r_flags;
        n_dx     = r_dx;
        o_q_push = 1'b0;
        if (i_accept) begin
            case (r_phase)
                PH_DX: begin
                    n_dx    = i_rx_byte;
                    n_phase = PH_DY;
                end
                PH_DY: begin
                    o_q_push = 1'b1;
                    n_phase  = PH_FLAGS;
                end
                default: begin
                    // byte without the sync bit is dropped to regain framing
                    if (i_rx_byte[SYNC_BIT]) begin
                        n_flags = i_rx_byte;
                        n_phase = PH_DX;
                    end else begin
                        n_phase = PH_FLAGS;
                    end
                end
            endcase
        end
    end

    assign o_q_data.flags = r_flags;
    assign o_q_data.dx    = r_dx;
    assign o_q_data.dy    = i_rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FLAGS;
            r_flags <= '0;
            r_dx    <= '0;
        end else begin
            r_phase <= n_phase;
            r_flags <= n_flags;
            r_dx    <= n_dx;
        end
    end

endmodule

// ===== design/ps2mct_queue.sv =====
module ps2mct_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ps2mct_pkg::t_packet i_data,
    input  logic                i_pop,
    output ps2mct_pkg::t_packet o_data,
    output logic                o_full,
    output logic                o_empty
);
    import ps2mct_pkg::*;

    t_packet            r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/ps2mct_motion.sv =====
module ps2mct_motion (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ps2mct_pkg::t_cfg_wr          i_cfg,
    input  ps2mct_pkg::t_packet          i_q_data,
    input  logic                         i_q_empty,
    output logic                         o_q_pop,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic [ps2mct_pkg::COORD_BITS-1:0] o_cursor_x,
    output logic [ps2mct_pkg::COORD_BITS-1:0] o_cursor_y,
    output logic                         o_left_pressed,
    output logic                         o_right_pressed,
    output logic                         o_middle_pressed,
    output logic                         o_motion_dropped
);
    import ps2mct_pkg::*;

    localparam int SUM_W = COORD_BITS + 3;
    localparam int CMP_W = (SIZE_W > REG_W) ? SIZE_W : REG_W;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [REG_W-1:0] v);
        logic [CMP_W-1:0] vw;
        logic [CMP_W-1:0] lim;
        vw  = CMP_W'(v);
        lim = CMP_W'(1) << COORD_BITS;
        if (vw == '0) begin
            return SIZE_W'(1);
        end else if (vw > lim) begin
            return SIZE_W'(lim);
        end else begin
            return SIZE_W'(vw);
        end
    endfunction

    function automatic logic [COORD_BITS-1:0] half(input logic [SIZE_W-1:0] s);
        return s[SIZE_W-1:1];
    endfunction

    function automatic logic [COORD_BITS-1:0] move_axis(
        input logic [COORD_BITS-1:0] pos,
        input logic [7:0]            raw,
        input logic                  neg,
        input logic                  invert,
        input logic [SIZE_W-1:0]     size
    );
        logic signed [SUM_W-1:0] d;
        logic signed [SUM_W-1:0] p;
        logic signed [SUM_W-1:0] lim;
        d = signed'({{(SUM_W-8){neg}}, raw});
        if (invert) begin
            d = -d;
        end
        p   = signed'(SUM_W'(pos)) + (d <<< 1);
        lim = signed'(SUM_W'(size)) - SUM_W'(1);
        if (p < 0) begin
            p = '0;
        end
        if (p > lim) begin
            p = lim;
        end
        return p[COORD_BITS-1:0];
    endfunction

    logic [SIZE_W-1:0]     r_size_x, r_size_y, n_size_x, n_size_y;
    logic [COORD_BITS-1:0] r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_x, r_out_y;
    logic [2:0]            r_out_btn;
    logic                  r_out_drop;
    logic                  take;
    logic                  dropped;
    logic [COORD_BITS-1:0] mv_x, mv_y;

    // next packet moves into the output register as soon as it is free or leaving
    assign take    = !i_q_empty && (!r_out_valid || i_pop);
    assign o_q_pop = take;
    assign dropped = i_q_data.flags[X_OVF_BIT] || i_q_data.flags[Y_OVF_BIT];

    assign mv_x = move_axis(r_pos_x, i_q_data.dx, i_q_data.flags[X_SIGN_BIT],
                            1'b0, r_size_x);
    assign mv_y = move_axis(r_pos_y, i_q_data.dy, i_q_data.flags[Y_SIGN_BIT],
                            1'b1, r_size_y);

    always_comb begin
        n_size_x = r_size_x;
        n_size_y = r_size_y;
        n_pos_x  = r_pos_x;
        n_pos_y  = r_pos_y;
        if (i_cfg.we) begin
            case (i_cfg.idx)
                REG_SCREEN_WIDTH: begin
                    n_size_x = eff_size(i_cfg.data);
                    n_pos_x  = half(eff_size(i_cfg.data));
                    n_pos_y  = half(r_size_y);
                end
                REG_SCREEN_HEIGHT: begin
                    n_size_y = eff_size(i_cfg.data);
                    n_pos_x  = half(r_size_x);
                    n_pos_y  = half(eff_size(i_cfg.data));
                end
                default: begin
                    n_size_x = r_size_x;
                end
            endcase
        end else if (take && !dropped) begin
            n_pos_x = mv_x;
            n_pos_y = mv_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x    <= eff_size(WIDTH_RESET);
            r_size_y    <= eff_size(HEIGHT_RESET);
            r_pos_x     <= half(eff_size(WIDTH_RESET));
            r_pos_y     <= half(eff_size(HEIGHT_RESET));
            r_out_valid <= 1'b0;
        end else begin
            r_size_x <= n_size_x;
            r_size_y <= n_size_y;
            r_pos_x  <= n_pos_x;
            r_pos_y  <= n_pos_y;
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_x    <= dropped ? r_pos_x : mv_x;
            r_out_y    <= dropped ? r_pos_y : mv_y;
            r_out_btn  <= i_q_data.flags[2:0];
            r_out_drop <= dropped;
        end
    end

    assign o_empty          = !r_out_valid;
    assign o_cursor_x       = r_out_x;
    assign o_cursor_y       = r_out_y;
    assign o_left_pressed   = r_out_btn[LEFT_BIT];
    assign o_right_pressed  = r_out_btn[RIGHT_BIT];
    assign o_middle_pressed = r_out_btn[MIDDLE_BIT];
    assign o_motion_dropped = r_out_drop;

endmodule

// ===== design/ps2_mouse_cursor_tracker.sv =====
// PS/2 mouse packet decoder with cursor tracking. One byte is taken per cycle
// while full is low; every third byte of a framed packet yields one result,
// which passes through the packet queue into the output register before it
// appears on the result ports, and is held there until popped. A first byte
// lacking the sync bit is dropped to regain framing. The back end does one
// add-and-clamp per axis per cycle, so one packet a cycle is drained while
// results are being popped; a two-entry queue lets the byte side keep running
// while the result side stalls. Writing either screen size recentres the
// cursor; sizes of zero act as one and sizes above the coordinate range are
// capped at it. Sizes may only be written while no packet is in flight.
`include "ps2_mouse_cursor_tracker_defines.svh"

module ps2_mouse_cursor_tracker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [7:0]                          i_rx_byte,
    output logic                                empty,
    input  logic                                pop,
    output logic [ps2mct_pkg::COORD_BITS-1:0]   o_cursor_x,
    output logic [ps2mct_pkg::COORD_BITS-1:0]   o_cursor_y,
    output logic                                o_left_pressed,
    output logic                                o_right_pressed,
    output logic                                o_middle_pressed,
    output logic                                o_motion_dropped,
    input  logic                                i_cfg_we,
    input  logic [ps2mct_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ps2mct_pkg::REG_W-1:0]        i_cfg_data
);
    import ps2mct_pkg::*;

    logic    accept;
    logic    q_push, q_pop, q_full, q_empty;
    t_packet q_in, q_out;
    t_cfg_wr cfg;

    assign full   = q_full;
    assign accept = push && !q_full;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    ps2mct_framer u_framer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_q_push  (q_push),
        .o_q_data  (q_in)
    );

    ps2mct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ps2mct_motion u_motion (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_q_data         (q_out),
        .i_q_empty        (q_empty),
        .o_q_pop          (q_pop),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_cursor_x       (o_cursor_x),
        .o_cursor_y       (o_cursor_y),
        .o_left_pressed   (o_left_pressed),
        .o_right_pressed  (o_right_pressed),
        .o_middle_pressed (o_middle_pressed),
        .o_motion_dropped (o_motion_dropped)
    );

    // framer only completes a packet on an accepted byte, so never into a full queue
    `PS2MCT_ASSERT(a_no_push_when_full, !(q_push && q_full))
    `PS2MCT_ASSERT(a_no_pop_when_empty, !(q_pop && q_empty))
    // a pushed beat is still queued or already moved on, never lost
    `PS2MCT_ASSERT_NEXT(a_push_lands, q_push, !q_empty || !empty)

endmodule
